>>> src/cfir_pkg.sv
// ----------------------------------------------------------------------------
// cfir_pkg
// Shared types and constants of the centered zero-padded FIR filter.
// ----------------------------------------------------------------------------
package cfir_pkg;

  localparam int SMP_W   = 16;
  localparam int COEF_W  = 16;
  localparam int TAPIX_W = 6;
  localparam int CNT_W   = 7;
  localparam int INV_W   = 17;
  localparam int CFG_W   = 17;
  localparam int PROD_W  = COEF_W + 1 + SMP_W;
  localparam int ACC_W   = PROD_W + 6;
  localparam int SPLIT   = 20;
  localparam int LO_W    = SPLIT + 1 + INV_W + 1;
  localparam int HI_W    = ACC_W - SPLIT + INV_W + 1;
  localparam int FULL_W  = ACC_W + INV_W + 2;
  localparam int NORM_SH = 31;
  localparam int Q_W     = FULL_W - NORM_SH;

  localparam logic CFG_TAP_COUNT = 1'b0;
  localparam logic CFG_INV_TAPS  = 1'b1;

  localparam logic FUNC_COEF   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic                     func;
    logic [TAPIX_W-1:0]       tap_index;
    logic [COEF_W-1:0]        coef_value;
    logic signed [SMP_W-1:0]  sample;
    logic                     frame_end;
  } in_word_t;

  typedef struct packed {
    logic signed [SMP_W-1:0]  filtered;
    logic                     last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic coef_we;
    logic smp_we;
    logic mac_clear;
    logic mac_issue;
    logic tap_zero;
    logic norm_lo;
    logic norm_hi;
    logic out_load;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

>>> src/centered_fir_zero_padded.sv
// ----------------------------------------------------------------------------
// centered_fir_zero_padded
// Centered FIR with zero padding at frame ends and reciprocal normalization.
// ----------------------------------------------------------------------------
// Coefficient words and sample words that owe no output leave the input free;
// after a sample word that owes outputs, the input stalls until each output it
// releases is done (L = effective tap count, D = L - 1 - L/2), and a frame_end
// sample releases up to D + 1 outputs. Each output is a pass of the single
// shared multiply-accumulate stepping one tap per cycle through the
// coefficient and sample memories, then pipeline drain, two normalization
// multiplies and the output load. An output waiting in the output register
// holds the next output at its load, and the input stalls meanwhile. No
// clearing pass after reset: the frame fill count masks stale samples.
// ----------------------------------------------------------------------------
module centered_fir_zero_padded #(
  parameter int MAX_TAPS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cfir_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cfir_pkg::out_word_t           out_word,
  input  logic                          cfg_we,
  input  logic                          cfg_addr,
  input  logic [cfir_pkg::CFG_W-1:0]    cfg_wdata
);
  import cfir_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int LW = $clog2(MAX_TAPS + 1);

  logic [CNT_W-1:0] tap_count_r;
  logic [INV_W-1:0] inv_taps_r;

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] tap_k;
  logic [AW-1:0] tap_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= CNT_W'(64);
      inv_taps_r  <= INV_W'(1024);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TAP_COUNT: tap_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_INV_TAPS:  inv_taps_r  <= cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  cfir_ctrl #(
    .MAX_TAPS (MAX_TAPS),
    .AW       (AW),
    .LW       (LW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_word.func),
    .in_tap_index (in_word.tap_index),
    .in_frame_end (in_word.frame_end),
    .tap_count    (tap_count_r),
    .sts          (sts),
    .cmd          (cmd),
    .tap_k        (tap_k),
    .tap_idx      (tap_idx)
  );

  cfir_dpath #(
    .MAX_TAPS (MAX_TAPS),
    .AW       (AW)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .coef_addr (in_word.tap_index),
    .coef_data (in_word.coef_value),
    .smp_data  (in_word.sample),
    .tap_k     (tap_k),
    .tap_idx   (tap_idx),
    .inv_taps  (inv_taps_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

>>> src/cfir_ctrl.sv
// ----------------------------------------------------------------------------
// cfir_ctrl
// Sequencer: input handshake, frame fill, output and tap stepping.
// ----------------------------------------------------------------------------
module cfir_ctrl #(
  parameter int MAX_TAPS = 64,
  parameter int AW       = 6,
  parameter int LW       = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_func,
  input  logic [cfir_pkg::TAPIX_W-1:0] in_tap_index,
  input  logic                         in_frame_end,
  input  logic [cfir_pkg::CNT_W-1:0]   tap_count,
  input  cfir_pkg::sts_t               sts,
  output cfir_pkg::cmd_t               cmd,
  output logic [AW-1:0]                tap_k,
  output logic [AW-1:0]                tap_idx
);
  import cfir_pkg::*;

  localparam int IW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_DRAIN1, S_DRAIN2, S_NORM_LO, S_NORM_HI, S_OUT
  } state_t;

  state_t        state_r;
  logic [AW-1:0] k_r;
  logic [AW-1:0] m_r;
  logic [LW-1:0] fill_r;
  logic          flush_r;

  logic          accept;
  logic [LW-1:0] len;
  logic [LW-1:0] half_l;
  logic [LW-1:0] d_l;
  logic [AW-1:0] half;
  logic [AW-1:0] d;
  logic [LW-1:0] fill_nxt;
  logic signed [IW-1:0] idx;

  always_comb begin
    if (tap_count == '0) begin
      len = LW'(1);
    end else if (tap_count > CNT_W'(MAX_TAPS)) begin
      len = LW'(MAX_TAPS);
    end else begin
      len = tap_count[LW-1:0];
    end
  end

  assign half_l   = len >> 1;
  assign d_l      = len - LW'(1) - half_l;
  assign half     = half_l[AW-1:0];
  assign d        = d_l[AW-1:0];
  assign fill_nxt = (fill_r == LW'(MAX_TAPS)) ? fill_r : fill_r + LW'(1);

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign idx = $signed(IW'(m_r)) + $signed(IW'(half)) - $signed(IW'(k_r));

  assign tap_k   = k_r;
  assign tap_idx = idx[AW-1:0];

  always_comb begin
    cmd           = '0;
    cmd.coef_we   = accept && (in_func == FUNC_COEF) &&
                    (TAPIX_W'(in_tap_index) < (TAPIX_W + 1)'(MAX_TAPS));
    cmd.smp_we    = accept && (in_func == FUNC_SAMPLE);
    cmd.mac_issue = (state_r == S_MAC);
    cmd.mac_clear = (state_r == S_MAC) && (k_r == '0);
    cmd.tap_zero  = (idx < 0) || (idx >= $signed(IW'(fill_r)));
    cmd.norm_lo   = (state_r == S_NORM_LO);
    cmd.norm_hi   = (state_r == S_NORM_HI);
    cmd.out_load  = (state_r == S_OUT) && sts.out_free;
    cmd.out_last  = flush_r && (m_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      m_r     <= '0;
      fill_r  <= '0;
      flush_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept && (in_func == FUNC_SAMPLE)) begin
            fill_r <= fill_nxt;
            k_r    <= '0;
            if (in_frame_end) begin
              flush_r <= 1'b1;
              m_r     <= (fill_r < LW'(d)) ? fill_r[AW-1:0] : d;
              state_r <= S_MAC;
            end else begin
              flush_r <= 1'b0;
              m_r     <= d;
              if (fill_r >= LW'(d)) begin
                state_r <= S_MAC;
              end
            end
          end
        end
        S_MAC: begin
          k_r <= k_r + AW'(1);
          if (LW'(k_r) == len - LW'(1)) begin
            state_r <= S_DRAIN1;
          end
        end
        S_DRAIN1:  state_r <= S_DRAIN2;
        S_DRAIN2:  state_r <= S_NORM_LO;
        S_NORM_LO: state_r <= S_NORM_HI;
        S_NORM_HI: state_r <= S_OUT;
        S_OUT: begin
          if (sts.out_free) begin
            if (!flush_r || (m_r == '0)) begin
              if (flush_r) begin
                fill_r <= '0;
              end
              state_r <= S_IDLE;
            end else begin
              m_r     <= m_r - AW'(1);
              k_r     <= '0;
              state_r <= S_MAC;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/cfir_dpath.sv
// ----------------------------------------------------------------------------
// cfir_dpath
// Coefficient and sample memories, shared MAC, normalization, output word.
// ----------------------------------------------------------------------------
module cfir_dpath #(
  parameter int MAX_TAPS = 64,
  parameter int AW       = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfir_pkg::cmd_t               cmd,
  output cfir_pkg::sts_t               sts,
  input  logic [cfir_pkg::TAPIX_W-1:0] coef_addr,
  input  logic [cfir_pkg::COEF_W-1:0]  coef_data,
  input  logic [cfir_pkg::SMP_W-1:0]   smp_data,
  input  logic [AW-1:0]                tap_k,
  input  logic [AW-1:0]                tap_idx,
  input  logic [cfir_pkg::INV_W-1:0]   inv_taps,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cfir_pkg::out_word_t          out_word
);
  import cfir_pkg::*;

  logic [COEF_W-1:0] coef_mem [MAX_TAPS];
  logic [SMP_W-1:0]  smp_mem  [MAX_TAPS];

  logic [AW-1:0]     wp_r;
  logic [AW-1:0]     wp_nxt;
  logic [AW:0]       rd_wide;
  logic [AW-1:0]     rd_addr;

  logic                     s1_v_r;
  logic                     s1_zero_r;
  logic [COEF_W-1:0]        coef_q_r;
  logic [SMP_W-1:0]         smp_q_r;
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [SMP_W-1:0]  smp_op;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [LO_W-1:0]   p_lo_r;
  logic signed [HI_W-1:0]   p_hi_r;
  logic signed [FULL_W-1:0] full;
  logic signed [Q_W-1:0]    q;
  logic signed [SMP_W-1:0]  sat;

  logic      out_valid_r;
  out_word_t out_word_r;

  assign wp_nxt  = (wp_r == AW'(MAX_TAPS - 1)) ? '0 : wp_r + AW'(1);
  assign rd_wide = ({1'b0, wp_r} >= {1'b0, tap_idx}) ?
                   {1'b0, wp_r} - {1'b0, tap_idx} :
                   {1'b0, wp_r} + (AW + 1)'(MAX_TAPS) - {1'b0, tap_idx};
  assign rd_addr = rd_wide[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.coef_we) begin
      coef_mem[coef_addr[AW-1:0]] <= coef_data;
    end
    if (cmd.smp_we) begin
      smp_mem[wp_nxt] <= smp_data;
    end
    coef_q_r <= coef_mem[tap_k];
    smp_q_r  <= smp_mem[rd_addr];
  end

  assign smp_op   = s1_zero_r ? '0 : $signed(smp_q_r);
  assign prod_nxt = $signed({1'b0, coef_q_r}) * smp_op;

  assign full = (FULL_W'(p_hi_r) <<< SPLIT) + FULL_W'(p_lo_r);
  assign q    = Q_W'(full >>> NORM_SH);

  always_comb begin
    if (q > $signed(Q_W'(32767))) begin
      sat = 16'sh7FFF;
    end else if (q < -$signed(Q_W'(32768))) begin
      sat = -16'sh8000;
    end else begin
      sat = q[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.mac_clear) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.norm_lo) begin
      p_lo_r <= $signed({1'b0, acc_r[SPLIT-1:0]}) * $signed({1'b0, inv_taps});
    end
    if (cmd.norm_hi) begin
      p_hi_r <= $signed(acc_r[ACC_W-1:SPLIT]) * $signed({1'b0, inv_taps});
    end
    if (cmd.out_load) begin
      out_word_r.filtered      <= sat;
      out_word_r.last_of_frame <= cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      s1_v_r      <= 1'b0;
      s1_zero_r   <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.smp_we) begin
        wp_r <= wp_nxt;
      end
      s1_v_r    <= cmd.mac_issue;
      s1_zero_r <= cmd.tap_zero;
      s2_v_r    <= s1_v_r;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;

endmodule
